### rtl/jpjs_pkg.sv
// ----------------------------------------------------------------------------
// jpjs_pkg
// Types and constants shared by the periodic job scheduler modules.
// ----------------------------------------------------------------------------
package jpjs_pkg;

  localparam int TIME_W = 32;
  localparam int PER_W  = 26;
  localparam int SPAN_W = 24;
  localparam int OFF_W  = 25;
  localparam int CYC_W  = 34;
  localparam int PROD_W = 60;
  localparam int WIDE_W = 62;
  localparam int SEED_W = 31;
  localparam int DIV_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ACCEPT  = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  localparam logic [0:0] REG_SEED = 1'b0;

  localparam logic [PER_W-1:0]  MAX_PERIOD  = 26'd63244800;
  localparam logic [11:0]       HORIZON     = 12'd3600;
  localparam logic [3:0]        BACK_CYCLES = 4'd10;
  localparam logic [SEED_W-1:0] RAND_TOP    = 31'h7FFFFFFF;
  localparam logic [TIME_W-1:0] DUE_MAX     = 32'hFFFFFFFF;
  localparam logic [4:0]        FIRE_CAP    = 5'd16;

  typedef enum logic [2:0] {
    EMIT_NONE = 3'd0,
    EMIT_FIRE = 3'd1,
    EMIT_SUM  = 3'd2,
    EMIT_ACC  = 3'd3,
    EMIT_REJ  = 3'd4
  } emit_t;

  typedef struct packed {
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] finish;
    logic [SPAN_W-1:0] span;
    logic [CYC_W-1:0]  cycle;
    logic [OFF_W-1:0]  offset;
  } slot_rec_t;

  typedef struct packed {
    logic  capture;
    logic  ld_init;
    logic  ld_cycle;
    logic  tk_init;
    logic  tk_load;
    logic  tk_base;
    logic  tk_check;
    logic  tk_resync_start;
    logic  tk_resync;
    logic  dr_lim_start;
    logic  dr_limit;
    logic  dr_step;
    logic  dr_offset;
    logic  dr_zero;
    logic  mem_write;
    logic  set_valid;
    logic  clr_valid;
    logic  idx_next;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       slot_ok;
    logic       period_ok;
    logic       span_zero;
    logic       slot_live;
    logic       div_busy;
    logic       mul_busy;
    logic       fire;
    logic       resync;
    logic       draw_ok;
    logic       idx_last;
    logic       cap_ok;
    logic       out_free;
  } status_t;

endpackage

### rtl/jpjs_div.sv
// ----------------------------------------------------------------------------
// jpjs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jpjs_div import jpjs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [PER_W-1:0]  divisor,
  output logic              busy,
  output logic [DIV_W-1:0]  quot,
  output logic [PER_W-1:0]  rem
);

  logic [PER_W-1:0] dsr;
  logic [5:0]       cnt;
  logic [PER_W:0]   trial;
  logic             take;

  assign trial = {rem, quot[DIV_W-1]};
  assign take  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr  <= divisor;
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], take};
      rem  <= take ? PER_W'(trial - {1'b0, dsr}) : trial[PER_W-1:0];
    end
  end

endmodule

### rtl/jpjs_mul.sv
// ----------------------------------------------------------------------------
// jpjs_mul
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module jpjs_mul import jpjs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CYC_W-1:0]  a,
  input  logic [PER_W-1:0]  b,
  output logic              busy,
  output logic [PROD_W-1:0] prod
);

  logic [CYC_W-1:0] a_r;
  logic [PER_W-1:0] b_r;
  logic [4:0]       cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(PER_W);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      b_r  <= {b_r[PER_W-2:0], 1'b0};
      prod <= {prod[PROD_W-2:0], 1'b0}
              + (b_r[PER_W-1] ? PROD_W'(a_r) : PROD_W'(0));
    end
  end

endmodule

### rtl/jpjs_ctrl.sv
// ----------------------------------------------------------------------------
// jpjs_ctrl
// Sequencer for load, clear and tick items of the job scheduler.
// ----------------------------------------------------------------------------
module jpjs_ctrl import jpjs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'b000000000000000001,
    S_DECODE   = 18'b000000000000000010,
    S_REJ      = 18'b000000000000000100,
    S_LD_DIV   = 18'b000000000000001000,
    S_DR_START = 18'b000000000000010000,
    S_DR_LIM   = 18'b000000000000100000,
    S_DR_STEP  = 18'b000000000001000000,
    S_DR_MOD   = 18'b000000000010000000,
    S_LD_EMIT  = 18'b000000000100000000,
    S_T_READ   = 18'b000000001000000000,
    S_T_LOAD   = 18'b000000010000000000,
    S_T_MUL    = 18'b000000100000000000,
    S_T_CHECK  = 18'b000001000000000000,
    S_T_EMIT   = 18'b000010000000000000,
    S_T_RESYNC = 18'b000100000000000000,
    S_T_WRITE  = 18'b001000000000000000,
    S_T_NEXT   = 18'b010000000000000000,
    S_T_SUM    = 18'b100000000000000000
  } state_t;

  state_t state, state_next;
  logic   is_load;

  assign is_load    = sts.func == FUNC_LOAD;
  assign item_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          FUNC_LOAD: begin
            if (!sts.slot_ok) begin
              state_next = S_IDLE;
            end else if (!sts.period_ok) begin
              state_next = S_REJ;
            end else begin
              cmd.ld_init = 1'b1;
              state_next  = S_LD_DIV;
            end
          end
          FUNC_CLEAR: begin
            cmd.clr_valid = sts.slot_ok;
            state_next    = S_IDLE;
          end
          FUNC_TICK: begin
            cmd.tk_init = 1'b1;
            state_next  = S_T_READ;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_REJ: begin
        if (sts.out_free) begin
          cmd.emit   = EMIT_REJ;
          state_next = S_IDLE;
        end
      end
      S_LD_DIV: begin
        if (!sts.div_busy) begin
          cmd.ld_cycle = 1'b1;
          state_next   = S_DR_START;
        end
      end
      S_DR_START: begin
        if (sts.span_zero) begin
          cmd.dr_zero = 1'b1;
          state_next  = is_load ? S_LD_EMIT : S_T_WRITE;
        end else begin
          cmd.dr_lim_start = 1'b1;
          state_next       = S_DR_LIM;
        end
      end
      S_DR_LIM: begin
        if (!sts.div_busy) begin
          cmd.dr_limit = 1'b1;
          state_next   = S_DR_STEP;
        end
      end
      S_DR_STEP: begin
        cmd.dr_step = 1'b1;
        if (sts.draw_ok) begin
          state_next = S_DR_MOD;
        end
      end
      S_DR_MOD: begin
        if (!sts.div_busy) begin
          cmd.dr_offset = 1'b1;
          state_next    = is_load ? S_LD_EMIT : S_T_WRITE;
        end
      end
      S_LD_EMIT: begin
        if (sts.out_free) begin
          cmd.mem_write = 1'b1;
          cmd.set_valid = 1'b1;
          cmd.emit      = EMIT_ACC;
          state_next    = S_IDLE;
        end
      end
      S_T_READ: state_next = S_T_LOAD;
      S_T_LOAD: begin
        if (!sts.slot_live) begin
          state_next = S_T_NEXT;
        end else begin
          cmd.tk_load = 1'b1;
          state_next  = S_T_MUL;
        end
      end
      S_T_MUL: begin
        if (!sts.mul_busy) begin
          cmd.tk_base = 1'b1;
          state_next  = S_T_CHECK;
        end
      end
      S_T_CHECK: begin
        cmd.tk_check = 1'b1;
        state_next   = sts.fire ? S_T_EMIT : S_T_WRITE;
      end
      S_T_EMIT: begin
        if (!sts.cap_ok || sts.out_free) begin
          if (sts.cap_ok) begin
            cmd.emit = EMIT_FIRE;
          end
          if (sts.resync) begin
            cmd.tk_resync_start = 1'b1;
            state_next          = S_T_RESYNC;
          end else begin
            state_next = S_DR_START;
          end
        end
      end
      S_T_RESYNC: begin
        if (!sts.div_busy) begin
          cmd.tk_resync = 1'b1;
          state_next    = S_DR_START;
        end
      end
      S_T_WRITE: begin
        cmd.mem_write = 1'b1;
        state_next    = S_T_NEXT;
      end
      S_T_NEXT: begin
        if (sts.idx_last) begin
          state_next = S_T_SUM;
        end else begin
          cmd.idx_next = 1'b1;
          state_next   = S_T_READ;
        end
      end
      S_T_SUM: begin
        if (sts.out_free) begin
          cmd.emit   = EMIT_SUM;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/jpjs_dp.sv
// ----------------------------------------------------------------------------
// jpjs_dp
// Slot table, working registers, jitter generator and result register.
// ----------------------------------------------------------------------------
module jpjs_dp import jpjs_pkg::*; #(
  parameter int JOB_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic [1:0]         func,
  input  logic [3:0]         slot,
  input  logic [TIME_W-1:0]  now,
  input  logic [PER_W-1:0]   period,
  input  logic [TIME_W-1:0]  window_start,
  input  logic [TIME_W-1:0]  window_end,
  input  logic [SPAN_W-1:0]  jitter_span,
  input  logic               cfg_write,
  input  logic [SEED_W-1:0]  cfg_data,
  output logic [SEED_W-1:0]  seed,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic [3:0]         fired_slot,
  output logic [TIME_W-1:0]  next_due,
  output logic               last
);

  localparam int IDX_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

  logic [1:0]        i_func;
  logic [3:0]        i_slot;
  logic [TIME_W-1:0] i_now, i_start, i_end;
  logic [PER_W-1:0]  i_period;
  logic [SPAN_W-1:0] i_span;

  logic [PER_W-1:0]         w_period;
  logic [TIME_W-1:0]        w_begin, w_finish;
  logic [SPAN_W-1:0]        w_span;
  logic signed [CYC_W-1:0]  w_cycle;
  logic signed [OFF_W-1:0]  w_offset;
  logic                     neg;
  logic signed [WIDE_W-1:0] base, best;
  logic                     fired;
  logic [4:0]               fire_cnt;
  logic [SEED_W-1:0]        limit, lfsr, lfsr_step, lfsr_cur;

  logic [JOB_SLOTS-1:0] slot_valid;
  slot_rec_t            slot_mem [JOB_SLOTS];
  slot_rec_t            rd, rec_w;
  logic [IDX_W-1:0]     idx, slot_idx, wr_addr;

  logic              div_start, div_busy;
  logic [DIV_W-1:0]  div_dividend, div_quot;
  logic [PER_W-1:0]  div_divisor, div_rem;
  logic              mul_busy;
  logic [CYC_W-1:0]  mul_a;
  logic [PROD_W-1:0] mul_prod;

  logic                     now_lt;
  logic [TIME_W-1:0]        abs_diff;
  logic [OFF_W-1:0]         modulus;
  logic                     draw_ok;
  logic signed [WIDE_W-1:0] now_w, begin_w, per_w, ten_per, off_w, prod_w;
  logic signed [WIDE_W-1:0] base_eff, due;
  logic signed [CYC_W-1:0]  cyc_eff, q_ext;
  logic                     after_start, jump_back, in_window, fire_now;
  logic signed [PER_W-1:0]  offset_raw;
  logic [TIME_W-1:0]        summary;
  logic                     out_free;

  assign slot_idx = IDX_W'(i_slot);
  assign wr_addr  = (i_func == FUNC_LOAD) ? slot_idx : idx;
  assign out_free = !result_valid || !result_stall;

  assign now_lt   = i_now < i_start;
  assign abs_diff = now_lt ? i_start - i_now : i_now - i_start;
  assign modulus  = {1'b0, w_span} + OFF_W'(1);

  assign lfsr_cur  = (lfsr == '0) ? SEED_W'(1) : lfsr;
  assign lfsr_step = {lfsr_cur[SEED_W-2:0], lfsr_cur[30] ^ lfsr_cur[27]};
  assign draw_ok   = lfsr_step < limit;

  always_comb begin
    div_start    = cmd.ld_init | cmd.tk_resync_start | cmd.dr_lim_start
                   | (cmd.dr_step & draw_ok);
    div_dividend = {1'b0, lfsr_step};
    div_divisor  = {1'b0, modulus};
    if (cmd.ld_init) begin
      div_dividend = abs_diff;
      div_divisor  = i_period;
    end else if (cmd.tk_resync_start) begin
      div_dividend = i_now - w_begin;
      div_divisor  = w_period;
    end else if (cmd.dr_lim_start) begin
      div_dividend = {1'b0, RAND_TOP};
    end
  end

  assign mul_a = rd.cycle[CYC_W-1] ? CYC_W'(-rd.cycle) : rd.cycle;

  jpjs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  jpjs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.tk_load),
    .a     (mul_a),
    .b     (rd.period),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  assign now_w   = $signed({{(WIDE_W-TIME_W){1'b0}}, i_now});
  assign begin_w = $signed({{(WIDE_W-TIME_W){1'b0}}, w_begin});
  assign per_w   = $signed({{(WIDE_W-PER_W){1'b0}}, w_period});
  assign ten_per = $signed(per_w * $signed({{(WIDE_W-4){1'b0}}, BACK_CYCLES}));
  assign off_w   = $signed({{(WIDE_W-OFF_W){w_offset[OFF_W-1]}}, w_offset});
  assign prod_w  = $signed({{(WIDE_W-PROD_W){1'b0}}, mul_prod});
  assign q_ext   = $signed({{(CYC_W-DIV_W){1'b0}}, div_quot});

  assign after_start = i_now >= w_begin;
  assign jump_back   = after_start && (now_w < base - ten_per);
  assign base_eff    = jump_back ? begin_w : base;
  assign cyc_eff     = jump_back ? '0 : w_cycle;
  assign due         = base_eff + off_w;
  assign in_window   = after_start && (i_now <= w_finish);
  assign fire_now    = in_window && (now_w >= due);

  assign offset_raw = $signed({1'b0, div_rem[OFF_W-1:0]})
                      - $signed({3'b0, w_span[SPAN_W-1:1]});

  always_comb begin
    if (fired || best < 0) begin
      summary = '0;
    end else if (best > $signed({{(WIDE_W-TIME_W){1'b0}}, DUE_MAX})) begin
      summary = DUE_MAX;
    end else begin
      summary = best[TIME_W-1:0];
    end
  end

  assign rec_w = '{period: w_period, start: w_begin, finish: w_finish, span: w_span,
                   cycle: w_cycle, offset: w_offset};

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      slot_mem[wr_addr] <= rec_w;
    end
    rd <= slot_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.set_valid) begin
      slot_valid[slot_idx] <= 1'b1;
    end else if (cmd.clr_valid) begin
      slot_valid[slot_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_W'(1);
      lfsr <= SEED_W'(1);
    end else if (cfg_write) begin
      seed <= cfg_data;
      lfsr <= (cfg_data == '0) ? SEED_W'(1) : cfg_data;
    end else if (cmd.dr_step) begin
      lfsr <= lfsr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      i_func   <= func;
      i_slot   <= slot;
      i_now    <= now;
      i_period <= period;
      i_start  <= window_start;
      i_end    <= window_end;
      i_span   <= jitter_span;
    end
    if (cmd.ld_init) begin
      w_period <= i_period;
      w_begin  <= i_start;
      w_finish <= i_end;
      w_span   <= i_span;
      neg      <= now_lt;
    end
    if (cmd.ld_cycle) begin
      w_cycle <= (neg ? -q_ext : q_ext) + CYC_W'(1);
    end
    if (cmd.tk_load) begin
      w_period <= rd.period;
      w_begin  <= rd.start;
      w_finish <= rd.finish;
      w_span   <= rd.span;
      w_cycle  <= $signed(rd.cycle);
      w_offset <= $signed(rd.offset);
      neg      <= rd.cycle[CYC_W-1];
    end
    if (cmd.tk_base) begin
      base <= begin_w + (neg ? -prod_w : prod_w);
    end
    if (cmd.tk_check) begin
      base    <= base_eff;
      w_cycle <= fire_now ? cyc_eff + CYC_W'(1) : cyc_eff;
    end
    if (cmd.tk_resync) begin
      w_cycle <= q_ext + CYC_W'(1);
    end
    if (cmd.dr_limit) begin
      limit <= RAND_TOP - SEED_W'(div_rem);
    end
    if (cmd.dr_offset) begin
      w_offset <= offset_raw[OFF_W-1:0];
    end
    if (cmd.dr_zero) begin
      w_offset <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tk_init) begin
      best     <= now_w + $signed({{(WIDE_W-12){1'b0}}, HORIZON});
      fired    <= 1'b0;
      fire_cnt <= '0;
      idx      <= '0;
    end else begin
      if (cmd.tk_check) begin
        if (fire_now) begin
          fired <= 1'b1;
        end else if (in_window && due < best) begin
          best <= due;
        end
      end
      if (cmd.emit == EMIT_FIRE) begin
        fire_cnt <= fire_cnt + 5'd1;
      end
      if (cmd.idx_next) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_FIRE: begin
        kind       <= KIND_FIRED;
        fired_slot <= 4'(idx);
        next_due   <= '0;
        last       <= 1'b0;
      end
      EMIT_SUM: begin
        kind       <= KIND_SUMMARY;
        fired_slot <= '0;
        next_due   <= summary;
        last       <= 1'b1;
      end
      EMIT_ACC: begin
        kind       <= KIND_ACCEPT;
        fired_slot <= i_slot;
        next_due   <= '0;
        last       <= 1'b1;
      end
      EMIT_REJ: begin
        kind       <= KIND_REJECT;
        fired_slot <= i_slot;
        next_due   <= '0;
        last       <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.func      = i_func;
    sts.slot_ok   = {5'd0, i_slot} < 9'(JOB_SLOTS);
    sts.period_ok = (i_period != '0) && (i_period <= MAX_PERIOD);
    sts.span_zero = w_span == '0;
    sts.slot_live = slot_valid[idx];
    sts.div_busy  = div_busy;
    sts.mul_busy  = mul_busy;
    sts.fire      = fire_now;
    sts.resync    = (base + per_w) <= now_w;
    sts.draw_ok   = draw_ok;
    sts.idx_last  = idx == IDX_W'(JOB_SLOTS - 1);
    sts.cap_ok    = fire_cnt < FIRE_CAP;
    sts.out_free  = out_free;
  end

endmodule

### rtl/jittered_periodic_job_scheduler.sv
// ----------------------------------------------------------------------------
// jittered_periodic_job_scheduler
// Table of periodic job slots with jittered firing times.
//
// Input channel (item_valid/item_stall) takes one beat per item: func selects
// load, clear or tick. The block works on one item at a time; item_stall is
// high from the beat after acceptance until the item is finished.
// Result channel (result_valid/result_stall) carries a registered beat; the
// block waits while a result is held. last marks the final beat of an item.
// A load runs one divide and, with a nonzero span, a jitter draw: the
// divide is used twice plus LFSR samples until one is accepted. A tick
// visits every slot: an idle slot is skipped, a live one runs the serial
// multiplier, plus one divide for a resync and a draw for each firing slot.
// Reset clears all slot valid bits and loads the seed and LFSR with 1; the
// slot table needs no clearing pass. random_seed sits at APB address 0.
// ----------------------------------------------------------------------------
module jittered_periodic_job_scheduler import jpjs_pkg::*; #(
  parameter int JOB_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         func,
  input  logic [3:0]         slot,
  input  logic [TIME_W-1:0]  now,
  input  logic [PER_W-1:0]   period,
  input  logic [TIME_W-1:0]  window_start,
  input  logic [TIME_W-1:0]  window_end,
  input  logic [SPAN_W-1:0]  jitter_span,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic [3:0]         fired_slot,
  output logic [TIME_W-1:0]  next_due,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cmd_t              cmd;
  status_t           sts;
  logic              cfg_write;
  logic [SEED_W-1:0] seed;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2:2] == REG_SEED);
  assign prdata    = (paddr[2:2] == REG_SEED) ? {1'b0, seed} : '0;

  jpjs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  jpjs_dp #(
    .JOB_SLOTS (JOB_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .slot         (slot),
    .now          (now),
    .period       (period),
    .window_start (window_start),
    .window_end   (window_end),
    .jitter_span  (jitter_span),
    .cfg_write    (cfg_write),
    .cfg_data     (pwdata[SEED_W-1:0]),
    .seed         (seed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .fired_slot   (fired_slot),
    .next_due     (next_due),
    .last         (last)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("accepted item did not raise stall");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_SUMMARY |-> last && fired_slot == 4'd0)
    else $error("summary beat malformed");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_FIRED |-> !last && next_due == '0)
    else $error("fire beat malformed");

  a_no_result_when_idle_load: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_ACCEPT || kind == KIND_REJECT) |-> last)
    else $error("load beat without last");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the jittered periodic job scheduler against a behavioral predictor.
// Directed loads, clears and ticks hit the extremes first, then random
// loads, clears and ticks (mostly advancing time) run under three idling
// phases, with a reseed of the jitter generator before each phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import jpjs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         LIMIT_CYCLES = 4000000;

  typedef struct {
    logic [1:0]        func;
    logic [3:0]        slot;
    logic [TIME_W-1:0] now;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] wstart;
    logic [TIME_W-1:0] wend;
    logic [SPAN_W-1:0] span;
  } job_item_t;

  typedef struct {
    logic [1:0]        kind;
    logic [3:0]        slot;
    logic [TIME_W-1:0] due;
    logic              last;
  } job_result_t;

  class sched_scoreboard;
    bit                live[16];
    bit [PER_W-1:0]    per[16];
    bit [TIME_W-1:0]   beg[16];
    bit [TIME_W-1:0]   fin[16];
    bit [SPAN_W-1:0]   spn[16];
    longint            cyc[16];
    longint            off[16];
    bit [SEED_W-1:0]   lfsr;
    job_result_t       expected_q[$];
    int                errors;

    function new();
      foreach (live[i]) live[i] = 0;
      lfsr = 1;
      errors = 0;
    endfunction

    function void reseed(bit [SEED_W-1:0] seed);
      lfsr = (seed == 0) ? 1 : seed;
    endfunction

    function bit [SEED_W-1:0] lfsr_advance();
      bit [SEED_W-1:0] s;
      s = (lfsr == 0) ? 1 : lfsr;
      s = {s[29:0], s[30] ^ s[27]};
      lfsr = s;
      return s;
    endfunction

    function longint jitter(bit [SPAN_W-1:0] span);
      longint m;
      longint lim;
      longint r;
      if (span == 0) return 0;
      m = longint'(span) + 1;
      lim = (longint'(RAND_TOP) / m) * m;
      do r = longint'(lfsr_advance()); while (r >= lim);
      return (r % m) - longint'(span / 2);
    endfunction

    function longint first_cycle(longint t, longint st, longint p);
      return (t - st) / p + 1;
    endfunction

    function void push(logic [1:0] k, logic [3:0] s, logic [31:0] d, logic l);
      job_result_t r;
      r.kind = k; r.slot = s; r.due = d; r.last = l;
      expected_q.push_back(r);
    endfunction

    function void note_item(job_item_t it);
      longint t;
      longint best;
      longint st;
      longint en;
      longint p;
      longint due;
      bit     ins;
      t = longint'(it.now);
      case (it.func)
        FUNC_LOAD: begin
          if (it.period == 0 || it.period > MAX_PERIOD) begin
            push(KIND_REJECT, it.slot, 0, 1);
          end else begin
            live[it.slot] = 1;
            per[it.slot] = it.period;
            beg[it.slot] = it.wstart;
            fin[it.slot] = it.wend;
            spn[it.slot] = it.span;
            cyc[it.slot] = first_cycle(t, longint'(it.wstart), longint'(it.period));
            off[it.slot] = jitter(it.span);
            push(KIND_ACCEPT, it.slot, 0, 1);
          end
        end
        FUNC_CLEAR: live[it.slot] = 0;
        FUNC_TICK: begin
          best = t + 3600;
          for (int i = 0; i < 16; i++) begin
            if (!live[i]) continue;
            st = longint'(beg[i]);
            en = longint'(fin[i]);
            p = longint'(per[i]);
            ins = (t >= st) && (t <= en);
            if (t >= st && t < st + (cyc[i] - 10) * p) cyc[i] = 0;
            due = st + cyc[i] * p + off[i];
            if (ins && t >= due) begin
              push(KIND_FIRED, i[3:0], 0, 0);
              best = 0;
              cyc[i] += 1;
              if (st + cyc[i] * p <= t) cyc[i] = first_cycle(t, st, p);
              off[i] = jitter(spn[i]);
            end else if (ins && due < best) begin
              best = due;
            end
          end
          if (best < 0) best = 0;
          if (best > longint'(DUE_MAX)) best = longint'(DUE_MAX);
          push(KIND_SUMMARY, 0, best[31:0], 1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(job_result_t got);
      job_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat kind %0d slot %0d", got.kind, got.slot);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("fired_slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.due !== want.due) begin
        $error("next_due: expected %0d, got %0d", want.due, got.due);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               item_valid = 0;
  logic               item_stall;
  logic [1:0]         func = FUNC_TICK;
  logic [3:0]         slot = 0;
  logic [TIME_W-1:0]  now = 0;
  logic [PER_W-1:0]   period = 0;
  logic [TIME_W-1:0]  window_start = 0;
  logic [TIME_W-1:0]  window_end = 0;
  logic [SPAN_W-1:0]  jitter_span = 0;
  logic               result_valid;
  logic               result_stall = 0;
  logic [1:0]         kind;
  logic [3:0]         fired_slot;
  logic [TIME_W-1:0]  next_due;
  logic               last;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [PADDR_W-1:0] paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  sched_scoreboard sb = new();
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              cycles = 0;
  logic [31:0]     sim_secs;

  jittered_periodic_job_scheduler dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    job_result_t got;
    if (!rst && result_valid && !result_stall) begin
      got.kind = kind; got.slot = fired_slot; got.due = next_due; got.last = last;
      sb.check_result(got);
    end
  end

  task automatic send_item(job_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid = 0;
      @(negedge clk);
    end
    func = it.func; slot = it.slot; now = it.now; period = it.period;
    window_start = it.wstart; window_end = it.wend; jitter_span = it.span;
    item_valid = 1;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    item_valid = 0;
    psel = 1; pwrite = 1; penable = 0;
    paddr = PADDR_W'({REG_SEED, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.reseed(value[SEED_W-1:0]);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain(int settle);
    item_valid = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic job_item_t make_item(logic [1:0] f, logic [3:0] s, logic [31:0] t,
                                          logic [25:0] p, logic [31:0] ws, logic [31:0] we,
                                          logic [23:0] sp);
    job_item_t it;
    it.func = f; it.slot = s; it.now = t; it.period = p;
    it.wstart = ws; it.wend = we; it.span = sp;
    return it;
  endfunction

  function automatic job_item_t random_item();
    int          pick;
    logic [25:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      p = 26'($urandom_range(1, 60));
      return make_item(FUNC_LOAD, 4'($urandom_range(0, 15)), sim_secs, p,
                       ($urandom_range(0, 4) == 0) ? sim_secs + $urandom_range(0, 100)
                                                   : sim_secs - $urandom_range(0, 300),
                       ($urandom_range(0, 3) == 0) ? DUE_MAX
                                                   : sim_secs + $urandom_range(100, 3000),
                       ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(0, 2 * p)));
    end
    if (pick < 20)
      return make_item(FUNC_CLEAR, 4'($urandom_range(0, 15)), $urandom, 26'($urandom),
                       $urandom, $urandom, 24'($urandom));
    if (pick < 86) begin
      sim_secs = sim_secs + $urandom_range(0, 40);
      return make_item(FUNC_TICK, 4'($urandom), sim_secs, 26'($urandom), $urandom,
                       $urandom, 24'($urandom));
    end
    if (pick < 92) begin
      sim_secs = sim_secs - $urandom_range(500, 3000);
      return make_item(FUNC_TICK, 4'($urandom), sim_secs, 26'($urandom), $urandom,
                       $urandom, 24'($urandom));
    end
    return make_item(2'($urandom_range(0, 3)), 4'($urandom), $urandom, 26'($urandom),
                     $urandom, $urandom, 24'($urandom));
  endfunction

  initial begin
    job_item_t plan[$];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_seed(32'd1);

    plan.push_back(make_item(FUNC_LOAD, 0, 5, 0, 0, 100, 3));
    plan.push_back(make_item(FUNC_LOAD, 1, 0, MAX_PERIOD, 0, DUE_MAX, 24'hFFFFFF));
    plan.push_back(make_item(FUNC_LOAD, 2, 9, MAX_PERIOD + 1, 0, 100, 0));
    plan.push_back(make_item(FUNC_LOAD, 15, 9, 26'h3FFFFFF, 0, 100, 0));
    plan.push_back(make_item(FUNC_LOAD, 3, DUE_MAX, 1, DUE_MAX, DUE_MAX, 0));
    plan.push_back(make_item(FUNC_LOAD, 6, DUE_MAX, 1, 0, DUE_MAX, 0));
    plan.push_back(make_item(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_TICK, 0, DUE_MAX, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_UNUSED, 7, 1234, 5, 0, 10, 1));
    plan.push_back(make_item(FUNC_CLEAR, 1, 0, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_CLEAR, 3, 0, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_CLEAR, 6, 0, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_LOAD, 4, 1000, 10, 1000, 5000, 4));
    plan.push_back(make_item(FUNC_LOAD, 5, 100, 7, 500, 900, 1));
    plan.push_back(make_item(FUNC_TICK, 0, 1003, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_TICK, 0, 1200, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_TICK, 0, 1020, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_TICK, 0, 600, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_TICK, 0, 2000, 0, 0, 0, 0));
    plan.push_back(make_item(FUNC_TICK, 0, 6000, 0, 0, 0, 0));
    foreach (plan[i]) send_item(plan[i]);

    for (int ph = 0; ph < 3; ph++) begin
      drain(200);
      case (ph)
        0: begin send_idle_pct = 37; recv_idle_pct = 86; write_seed(32'h7FFFFFFF); end
        1: begin send_idle_pct = 86; recv_idle_pct = 37; write_seed(32'd0); end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; write_seed($urandom); end
      endcase
      sim_secs = $urandom_range(10000, 32'hF0000000);
      for (int n = 0; n < 140; n++) begin
        if (n == 70) drain(0);
        send_item(random_item());
      end
    end

    drain(400);
    if (sb.errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
